/* hw/rtl/stable_priority_queue_top_defines.svh */
// assertion macros for the stable priority queue
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SPQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq check failed");

`endif

/* hw/rtl/spq_pkg.sv */
package spq_pkg;
	localparam int QueueDepthDef = 64;
	localparam int DataWidthDef = 32;

	localparam logic [2:0] StJoined = 3'd0;
	localparam logic [2:0] StNewLower = 3'd1;
	localparam logic [2:0] StWasEmpty = 3'd2;
	localparam logic [2:0] StNewTop = 3'd3;
	localparam logic [2:0] StFull = 3'd4;

	localparam logic ActInsert = 1'b0;
	localparam logic ActRemove = 1'b1;

	typedef struct packed {
		logic action;
		logic [7:0] priority_req;
		logic [31:0] item_data;
	} in_item_t;

	typedef struct packed {
		logic [2:0] insert_status;
		logic removed_valid;
		logic [31:0] removed_data;
		logic head_valid;
		logic [31:0] head_data;
		logic [6:0] entry_count;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture input item
		logic apply;  // do the shift and write the result register
	} spq_cmd_t;
endpackage

/* hw/rtl/stable_priority_queue_top.sv */
// stable priority queue, shift-register slots with parallel compare
// sequence: the input transfer loads the request register, EXEC does the shift and writes the result
// register, SHOW offers the result; no new item is taken until the result has been taken
// reset: arst_n clears all slot valid bits, the count and the controller
// slot payload is not reset; only valid slots reach the outputs
module stable_priority_queue_top import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int DATA_WIDTH = DataWidthDef
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);
	spq_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	spq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data), .out_item(out_data)
	);
endmodule

/* hw/rtl/spq_datapath.sv */
module spq_datapath import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int DATA_WIDTH = DataWidthDef
) (
	input logic clk,
	input logic arst_n,
	input spq_cmd_t cmd,
	input in_item_t in_item,
	output out_item_t out_item
);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [7:0] prio_q [QUEUE_DEPTH];
	logic [DATA_WIDTH-1:0] data_q [QUEUE_DEPTH];
	logic [CW-1:0] count_q;
	in_item_t req_s1;
	out_item_t out_q;

	logic [QUEUE_DEPTH-1:0] ge_vec;
	logic [QUEUE_DEPTH-1:0] eq_vec;
	logic full;
	logic is_ins;
	logic is_rem;
	logic [DATA_WIDTH-1:0] new_data;
	logic [2:0] status;
	logic [CW-1:0] next_count;
	logic [DATA_WIDTH-1:0] next_head;

	assign new_data = DATA_WIDTH'(req_s1.item_data);
	assign full = valid_q[QUEUE_DEPTH-1];
	assign is_ins = (req_s1.action == ActInsert) && !full;
	assign is_rem = (req_s1.action == ActRemove) && valid_q[0];

	// per-slot compares against the request priority
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ge_vec[i] = valid_q[i] && (prio_q[i] >= req_s1.priority_req);
			eq_vec[i] = valid_q[i] && (prio_q[i] == req_s1.priority_req);
		end
	end

	always_comb begin
		if (req_s1.action == ActRemove) begin
			status = StJoined;
		end else if (full) begin
			status = StFull;
		end else if (!valid_q[0]) begin
			status = StWasEmpty;
		end else if (|eq_vec) begin
			status = StJoined;
		end else if (req_s1.priority_req > prio_q[0]) begin
			status = StNewTop;
		end else begin
			status = StNewLower;
		end
	end

	always_comb begin
		next_count = count_q;
		if (is_ins) next_count = count_q + 1'b1;
		else if (is_rem) next_count = count_q - 1'b1;
		if (is_ins) next_head = ge_vec[0] ? data_q[0] : new_data;
		else if (is_rem) next_head = data_q[1 % QUEUE_DEPTH];
		else next_head = data_q[0];
	end

	// shift-register slots: insert shifts down below the position, remove shifts up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.apply) begin
			count_q <= next_count;
			if (is_ins) valid_q <= {valid_q[QUEUE_DEPTH-2:0], 1'b1};
			else if (is_rem) valid_q <= {1'b0, valid_q[QUEUE_DEPTH-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_s1 <= in_item;
		if (cmd.apply) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (is_ins && !ge_vec[i]) begin
					if (i == 0 || ge_vec[(i == 0) ? 0 : i-1]) begin
						prio_q[i] <= req_s1.priority_req;
						data_q[i] <= new_data;
					end else begin
						prio_q[i] <= prio_q[(i == 0) ? 0 : i-1];
						data_q[i] <= data_q[(i == 0) ? 0 : i-1];
					end
				end else if (is_rem && i < QUEUE_DEPTH-1) begin
					prio_q[i] <= prio_q[(i + 1) % QUEUE_DEPTH];
					data_q[i] <= data_q[(i + 1) % QUEUE_DEPTH];
				end
			end
			out_q.insert_status <= status;
			out_q.removed_valid <= is_rem;
			out_q.removed_data <= is_rem ? 32'(data_q[0]) : '0;
			out_q.head_valid <= (next_count != '0);
			out_q.head_data <= (next_count != '0) ? 32'(next_head) : '0;
			out_q.entry_count <= 7'(next_count);
		end
	end

	assign out_item = out_q;
endmodule

/* hw/rtl/spq_ctrl.sv */
module spq_ctrl import spq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output spq_cmd_t cmd
);
	`include "stable_priority_queue_top_defines.svh"

	typedef enum logic [1:0] {IDLE, EXEC, SHOW} state_t;
	state_t state_q;

	assign in_ready = (state_q == IDLE);
	assign out_valid = (state_q == SHOW);
	assign cmd.load = in_valid && in_ready;
	assign cmd.apply = (state_q == EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: if (in_valid) state_q <= EXEC;
				EXEC: state_q <= SHOW;
				SHOW: if (out_ready) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	`SPQ_ASSERT_NEXT(a_load_exec, cmd.load, cmd.apply)
	`SPQ_ASSERT_NEXT(a_exec_show, cmd.apply, out_valid)
	`SPQ_ASSERT_IMPL(a_excl, out_valid, !in_ready && !cmd.apply)
endmodule
